// ===== rtl/smsb_pkg.sv =====
`timescale 1ns / 1ps
package smsb_pkg;

  // Item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam int ADDR_W  = 9;    // bitmap byte address
  localparam int DEPTH   = 512;  // bitmap bytes
  localparam int BOX_W   = 7;    // box size field
  localparam int DVD_W   = 12;   // divider dividend, holds 63 * 64
  localparam logic [BOX_W-1:0] MAX_BOX = 7'd64;

  typedef struct packed {
    logic        operation;
    logic [8:0]  byte_address;
    logic [7:0]  byte_value;
    logic [5:0]  row_index;
    logic [6:0]  box_size;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [15:0] pixel_color;
  } blit_in_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [15:0] color_out;
    logic        last_pixel;
  } blit_out_t;

  typedef struct packed {
    logic             go;
    logic [DVD_W-1:0] dividend;
    logic [BOX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quo;
    logic [BOX_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/smsb_div.sv =====
`timescale 1ns / 1ps
module smsb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  smsb_pkg::div_req_t  req,
  output smsb_pkg::div_rsp_t  rsp
);
  import smsb_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;   // dividend shifts out, quotient shifts in
  logic [BOX_W-1:0] rem_r;
  logic [BOX_W-1:0] dsr_r;

  logic [BOX_W:0]   partial;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign partial = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = (partial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.go) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
    if (req.go) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? BOX_W'(partial - {1'b0, dsr_r}) : partial[BOX_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/smsb_store.sv =====
`timescale 1ns / 1ps
module smsb_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [smsb_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        rd_en,
  input  logic [smsb_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                  rd_data
);
  import smsb_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/scaled_mono_sprite_blitter_unit.sv =====
`timescale 1ns / 1ps
// Scaled 1bpp sprite blitter.
// Input channel: an item is taken on a clock edge with start high and busy
// low. A load item writes one bitmap byte in that same edge and leaves busy
// low, so loads can stream one per cycle. A draw item renders one output row
// of a nearest-neighbor scaled copy of the SRC_SIZE x SRC_SIZE bitmap.
// Result channel: every box column of the row whose sampled source pixel
// is set gives one item on out_item with out_strobe high for one cycle;
// last_pixel marks the final one. The receiver cannot stall, the block
// never waits on it. A draw runs two passes of the shared divider (source
// row, then the per-column step), each a launch, 12 quotient bits and
// done, then steps the box columns through the bitmap RAM read port and
// drains. A draw with zero box size or a row outside the box leaves busy
// low and emits nothing. The last result is strobed in the cycle busy
// drops. Bitmap RAM contents are undefined until written; reset clears
// only control state.
module scaled_mono_sprite_blitter_unit #(
  parameter int SRC_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smsb_pkg::blit_in_t  in_item,
  output logic                out_strobe,
  output smsb_pkg::blit_out_t out_item
);
  import smsb_pkg::*;

  localparam int SXW       = $clog2(SRC_SIZE);
  localparam int ROW_BYTES = (SRC_SIZE + 7) / 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_Y,   // sy = dy * SRC / size
    ST_DIV_Q,   // q, r = SRC / size
    ST_SCAN,    // one column per cycle into the RAM read port
    ST_DRAIN    // last column out of the RAM, flush pending pixel
  } state_t;

  state_t           state_r, state_nxt;

  // draw item context
  logic [BOX_W-1:0] size_r, size_nxt;
  logic [5:0]       dy_r, dy_nxt;
  logic [9:0]       ox_r, ox_nxt;
  logic [9:0]       oy_r, oy_nxt;
  logic [15:0]      color_r, color_nxt;
  logic [SXW-1:0]   sy_r, sy_nxt;
  logic [BOX_W-1:0] q_r, q_nxt;
  logic [BOX_W-1:0] r_r, r_nxt;

  // column stepper: dx * SRC = sx * size + rem
  logic [5:0]       dx_r, dx_nxt;
  logic [SXW-1:0]   sx_r, sx_nxt;
  logic [BOX_W-1:0] rem_r, rem_nxt;

  // read pipeline stage
  logic             p_vld_r, p_vld_nxt;
  logic [5:0]       p_dx_r, p_dx_nxt;
  logic [2:0]       p_bit_r, p_bit_nxt;

  // pixel held back until we know if it is the last one
  logic             pend_vld_r, pend_vld_nxt;
  logic [5:0]       pend_dx_r, pend_dx_nxt;

  logic             div_go_r, div_go_nxt;
  logic [DVD_W-1:0] div_dvd_r, div_dvd_nxt;

  logic             out_strobe_r, out_strobe_nxt;
  blit_out_t        out_item_r, out_item_nxt;

  div_req_t         dreq;
  div_rsp_t         drsp;

  logic             accept;
  logic [BOX_W-1:0] size_sat;
  logic [BOX_W:0]   rem_sum;
  logic             wrap;
  logic [7:0]       sx_sum;
  logic [9:0]       addr_full;
  logic [7:0]       rd_data;
  logic             hit;
  logic             dx_last;
  logic             emit;
  logic             emit_last;

  assign accept   = start && !busy;
  assign size_sat = (in_item.box_size > MAX_BOX) ? MAX_BOX : in_item.box_size;

  // per-column step, one add and compare
  assign rem_sum = {1'b0, rem_r} + {1'b0, r_r};
  assign wrap    = (rem_sum >= {1'b0, size_r});
  assign sx_sum  = 8'(sx_r) + 8'(q_r) + 8'(wrap);
  assign dx_last = (BOX_W'(dx_r) == size_r - BOX_W'(1));

  assign addr_full = 10'(sy_r) * 10'(ROW_BYTES) + 10'(sx_r >> 3);

  assign hit = p_vld_r && rd_data[3'd7 - p_bit_r];

  assign dreq.go       = div_go_r;
  assign dreq.dividend = div_dvd_r;
  assign dreq.divisor  = size_r;

  smsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  smsb_store u_store (
    .clk     (clk),
    .wr_en   (accept && in_item.operation == OP_LOAD),
    .wr_addr (in_item.byte_address),
    .wr_data (in_item.byte_value),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (addr_full[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    dy_nxt       = dy_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    color_nxt    = color_r;
    sy_nxt       = sy_r;
    q_nxt        = q_r;
    r_nxt        = r_r;
    dx_nxt       = dx_r;
    sx_nxt       = sx_r;
    rem_nxt      = rem_r;
    p_vld_nxt    = 1'b0;
    p_dx_nxt     = dx_r;
    p_bit_nxt    = sx_r[2:0];
    pend_vld_nxt = pend_vld_r;
    pend_dx_nxt  = pend_dx_r;
    div_go_nxt   = 1'b0;
    div_dvd_nxt  = div_dvd_r;
    emit         = 1'b0;
    emit_last    = 1'b0;

    // a set column releases the previously held pixel
    if (hit) begin
      emit         = pend_vld_r;
      pend_vld_nxt = 1'b1;
      pend_dx_nxt  = p_dx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.operation == OP_DRAW) begin
          size_nxt     = size_sat;
          dy_nxt       = in_item.row_index;
          ox_nxt       = in_item.origin_x;
          oy_nxt       = in_item.origin_y;
          color_nxt    = in_item.pixel_color;
          pend_vld_nxt = 1'b0;
          div_dvd_nxt  = DVD_W'(in_item.row_index) * DVD_W'(SRC_SIZE);
          // empty box or row outside it: nothing to draw
          if (size_sat != '0 && BOX_W'(in_item.row_index) < size_sat) begin
            div_go_nxt = 1'b1;
            state_nxt  = ST_DIV_Y;
          end
        end
      end
      ST_DIV_Y: begin
        if (drsp.done) begin
          sy_nxt      = drsp.quo[SXW-1:0];
          div_dvd_nxt = DVD_W'(SRC_SIZE);
          div_go_nxt  = 1'b1;
          state_nxt   = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        if (drsp.done) begin
          q_nxt     = drsp.quo[BOX_W-1:0];
          r_nxt     = drsp.rem;
          dx_nxt    = '0;
          sx_nxt    = '0;
          rem_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        p_vld_nxt = 1'b1;
        dx_nxt    = dx_r + 6'd1;
        sx_nxt    = sx_sum[SXW-1:0];
        rem_nxt   = wrap ? BOX_W'(rem_sum - {1'b0, size_r}) : rem_sum[BOX_W-1:0];
        if (dx_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p_vld_r) begin
          emit         = pend_vld_r;
          emit_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_strobe_nxt          = emit;
    out_item_nxt.pixel_x    = 11'(ox_r) + 11'(pend_dx_r);
    out_item_nxt.pixel_y    = 11'(oy_r) + 11'(dy_r);
    out_item_nxt.color_out  = color_r;
    out_item_nxt.last_pixel = emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      p_vld_r      <= 1'b0;
      pend_vld_r   <= 1'b0;
      div_go_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      p_vld_r      <= p_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      div_go_r     <= div_go_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    size_r     <= size_nxt;
    dy_r       <= dy_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    color_r    <= color_nxt;
    sy_r       <= sy_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    dx_r       <= dx_nxt;
    sx_r       <= sx_nxt;
    rem_r      <= rem_nxt;
    p_dx_r     <= p_dx_nxt;
    p_bit_r    <= p_bit_nxt;
    pend_dx_r  <= pend_dx_nxt;
    div_dvd_r  <= div_dvd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  // results only come out of a draw in progress
  a_strobe_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a draw in progress");

  // the last pixel closes the row; nothing follows right after it
  a_last_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last_pixel) |=> !out_strobe)
    else $error("result strobe right after the last pixel");

  // a load never occupies the block
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == OP_LOAD) |=> !busy)
    else $error("busy raised by a load item");
`endif

endmodule
